@@ sv/assert_macros.svh @@
// assertion helpers included by eio_ctrl
// each one samples on clk_i and is disabled while rst_ni is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define EIO_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define EIO_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/eio_pkg.sv @@
// ----------------------------------------------------------------------------
// eio_pkg
// Shared types, codes and field widths of the elevator request scheduler.
// ----------------------------------------------------------------------------
package eio_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;
  localparam int TAG_BITS_DEF    = 8;

  localparam int START_W  = 32;
  localparam int LEN_W    = 16;
  localparam int SEG_W    = 7;
  localparam int BLEN_W   = 22;
  localparam int POS_W    = 41;
  localparam int NSUM_W   = 13;
  localparam int LIMIT_W  = 11;
  localparam int STATUS_W = 3;
  localparam int TYPE_W   = 2;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;

  // entry packing: start, length, write flag, segments, then tag on top
  localparam int ENT_LEN_LSB = START_W;
  localparam int ENT_WR_BIT  = START_W + LEN_W;
  localparam int ENT_SEG_LSB = ENT_WR_BIT + 1;
  localparam int ENT_TAG_LSB = ENT_SEG_LSB + SEG_W;

  localparam logic [TYPE_W-1:0] REQ_SUBMIT   = 2'd0;
  localparam logic [TYPE_W-1:0] REQ_CANCEL   = 2'd1;
  localparam logic [TYPE_W-1:0] REQ_DISPATCH = 2'd2;
  localparam logic [TYPE_W-1:0] REQ_RSVD     = 2'd3;

  localparam logic [STATUS_W-1:0] ST_ACCEPTED  = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_MEMBER    = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 3'd5;

  localparam logic [1:0] REG_BIDIR   = 2'd0;
  localparam logic [1:0] REG_SEG_LIM = 2'd1;
  localparam logic [1:0] REG_DEV_BLK = 2'd2;

  localparam logic                BIDIR_RST   = 1'b1;
  localparam logic [LIMIT_W-1:0]  SEG_LIM_RST = 11'd512;
  localparam logic [START_W-1:0]  DEV_BLK_RST = 32'hFFFF_FFFF;

  typedef struct packed {
    logic               bidir;
    logic [LIMIT_W-1:0] seg_limit;
    logic [START_W-1:0] dev_blocks;
  } cfg_t;

endpackage

@@ sv/eio_ram.sv @@
// ----------------------------------------------------------------------------
// eio_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module eio_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/eio_cfg.sv @@
// ----------------------------------------------------------------------------
// eio_cfg
// APB register file: sweep mode, segment limit and device size.
// ----------------------------------------------------------------------------
module eio_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [eio_pkg::ADDR_W-1:0] paddr,
  input  logic [eio_pkg::DATA_W-1:0] pwdata,
  output logic [eio_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output eio_pkg::cfg_t              cfg_o
);

  eio_pkg::cfg_t cfg_q, cfg_d;
  logic [1:0]    reg_idx;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (reg_idx)
        eio_pkg::REG_BIDIR:   cfg_d.bidir      = pwdata[0];
        eio_pkg::REG_SEG_LIM: cfg_d.seg_limit  = pwdata[eio_pkg::LIMIT_W-1:0];
        eio_pkg::REG_DEV_BLK: cfg_d.dev_blocks = pwdata[eio_pkg::START_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      eio_pkg::REG_BIDIR:   prdata = {{(eio_pkg::DATA_W-1){1'b0}}, cfg_q.bidir};
      eio_pkg::REG_SEG_LIM: prdata = eio_pkg::DATA_W'(cfg_q.seg_limit);
      eio_pkg::REG_DEV_BLK: prdata = cfg_q.dev_blocks;
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bidir      <= eio_pkg::BIDIR_RST;
      cfg_q.seg_limit  <= eio_pkg::SEG_LIM_RST;
      cfg_q.dev_blocks <= eio_pkg::DEV_BLK_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ sv/eio_ctrl.sv @@
// ----------------------------------------------------------------------------
// eio_ctrl
// Sequencer over the rank-ordered entry RAM: insert, cancel, dispatch, shift.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module eio_ctrl #(
  parameter int QUEUE_DEPTH = eio_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = eio_pkg::TAG_BITS_DEF,
  localparam int ENT_W      = eio_pkg::ENT_TAG_LSB + TAG_BITS,
  localparam int IDX_W      = $clog2(QUEUE_DEPTH),
  localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  eio_pkg::cfg_t                cfg_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [eio_pkg::TYPE_W-1:0]   req_type_i,
  input  logic [TAG_BITS-1:0]          req_tag_i,
  input  logic [eio_pkg::START_W-1:0]  start_block_i,
  input  logic [eio_pkg::LEN_W-1:0]    block_count_i,
  input  logic                         is_write_i,
  input  logic [eio_pkg::SEG_W-1:0]    segment_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [eio_pkg::STATUS_W-1:0] status_o,
  output logic [TAG_BITS-1:0]          out_tag_o,
  output logic [eio_pkg::START_W-1:0]  batch_start_o,
  output logic [eio_pkg::BLEN_W-1:0]   batch_length_o,
  output logic                         batch_write_o,
  output logic                         last_o,
  output logic                         ram_we_o,
  output logic [IDX_W-1:0]             ram_waddr_o,
  output logic [ENT_W-1:0]             ram_wdata_o,
  output logic                         ram_re_o,
  output logic [IDX_W-1:0]             ram_raddr_o,
  input  logic [ENT_W-1:0]             ram_rdata_i
);

  typedef enum logic [14:0] {
    S_IDLE    = 15'h0001,
    S_INS_RD  = 15'h0002,
    S_INS_CHK = 15'h0004,
    S_CAN_RD  = 15'h0008,
    S_CAN_CHK = 15'h0010,
    S_FND_RD  = 15'h0020,
    S_FND_CHK = 15'h0040,
    S_MRG_RD  = 15'h0080,
    S_MRG_CHK = 15'h0100,
    S_EMT_RD  = 15'h0200,
    S_EMT_CHK = 15'h0400,
    S_SHF_RD  = 15'h0800,
    S_SHF_WR  = 15'h1000,
    S_RESP    = 15'h2000,
    S_FIN     = 15'h4000
  } state_e;

  state_e                        state_q, state_d;
  logic [CNT_W-1:0]              count_q, count_d;
  logic [CNT_W-1:0]              cur_q, cur_d;
  logic [CNT_W-1:0]              dst_q, dst_d;
  logic [CNT_W-1:0]              amt_q, amt_d;
  logic [CNT_W-1:0]              lo_q, lo_d;
  logic [CNT_W-1:0]              hi_q, hi_d;
  logic                          fwd_q, fwd_d;
  logic [eio_pkg::START_W-1:0]   head_q, head_d;
  logic [1:0]                    attempt_q, attempt_d;
  logic                          first_q, first_d;
  logic                          at_end_q, at_end_d;
  logic                          disp_q, disp_d;
  logic                          type_q, type_d;
  logic [eio_pkg::POS_W-1:0]     pos_q, pos_d;
  logic [eio_pkg::NSUM_W-1:0]    nsum_q, nsum_d;
  logic [eio_pkg::BLEN_W-1:0]    blen_q, blen_d;
  logic [eio_pkg::START_W-1:0]   bstart_q, bstart_d;
  logic [ENT_W-1:0]              new_q, new_d;
  logic [eio_pkg::STATUS_W-1:0]  rstat_q, rstat_d;
  logic [TAG_BITS-1:0]           rtag_q, rtag_d;

  logic                          ovalid_q, ovalid_d;
  logic [eio_pkg::STATUS_W-1:0]  ostat_q, ostat_d;
  logic [TAG_BITS-1:0]           otag_q, otag_d;
  logic [eio_pkg::START_W-1:0]   obs_q, obs_d;
  logic [eio_pkg::BLEN_W-1:0]    obl_q, obl_d;
  logic                          owr_q, owr_d;
  logic                          olast_q, olast_d;
  logic                          out_free;

  logic [eio_pkg::START_W-1:0]   e_start;
  logic [eio_pkg::LEN_W-1:0]     e_len;
  logic                          e_wr;
  logic [eio_pkg::SEG_W-1:0]     e_seg;
  logic [TAG_BITS-1:0]           e_tag;

  logic                          t_fwd;
  logic [eio_pkg::START_W-1:0]   t_head;
  logic [eio_pkg::POS_W-1:0]     pe;
  logic [eio_pkg::START_W:0]     join_sum;
  logic                          etype;
  logic [eio_pkg::NSUM_W-1:0]    nsum_new;
  logic                          take;
  logic [CNT_W-1:0]              lo_new;
  logic [CNT_W-1:0]              hi_new;
  logic [CNT_W:0]                src;
  logic                          is_last;

  assign e_start = ram_rdata_i[eio_pkg::START_W-1:0];
  assign e_len   = ram_rdata_i[eio_pkg::ENT_LEN_LSB +: eio_pkg::LEN_W];
  assign e_wr    = ram_rdata_i[eio_pkg::ENT_WR_BIT];
  assign e_seg   = ram_rdata_i[eio_pkg::ENT_SEG_LSB +: eio_pkg::SEG_W];
  assign e_tag   = ram_rdata_i[eio_pkg::ENT_TAG_LSB +: TAG_BITS];

  assign out_free = !ovalid_q || !out_stall_i;
  assign t_fwd    = cfg_i.bidir ? !fwd_q : 1'b1;
  assign t_head   = t_fwd ? '0 : cfg_i.dev_blocks;

  // backward merge: the head slides down to a neighbor that ends where it sits
  assign join_sum = {1'b0, e_start} + (eio_pkg::START_W + 1)'(e_len);
  always_comb begin
    if (first_q) begin
      pe = eio_pkg::POS_W'(e_start);
    end else if (!fwd_q && (eio_pkg::POS_W'(join_sum) == pos_q)) begin
      pe = eio_pkg::POS_W'(e_start);
    end else begin
      pe = pos_q;
    end
  end
  assign etype    = first_q ? e_wr : type_q;
  assign nsum_new = nsum_q + eio_pkg::NSUM_W'(e_seg);
  assign take     = (pe == eio_pkg::POS_W'(e_start)) && (e_wr == etype) &&
                    (first_q || (nsum_new < eio_pkg::NSUM_W'(cfg_i.seg_limit)));
  assign lo_new   = (first_q || !fwd_q) ? cur_q : lo_q;
  assign hi_new   = (first_q || fwd_q) ? cur_q : hi_q;
  assign src      = {1'b0, dst_q} + {1'b0, amt_q};
  assign is_last  = (cur_q == hi_q);

  always_comb begin
    state_d   = state_q;
    count_d   = count_q;
    cur_d     = cur_q;
    dst_d     = dst_q;
    amt_d     = amt_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    fwd_d     = fwd_q;
    head_d    = head_q;
    attempt_d = attempt_q;
    first_d   = first_q;
    at_end_d  = at_end_q;
    disp_d    = disp_q;
    type_d    = type_q;
    pos_d     = pos_q;
    nsum_d    = nsum_q;
    blen_d    = blen_q;
    bstart_d  = bstart_q;
    new_d     = new_q;
    rstat_d   = rstat_q;
    rtag_d    = rtag_q;
    ovalid_d  = ovalid_q && out_stall_i;
    ostat_d   = ostat_q;
    otag_d    = otag_q;
    obs_d     = obs_q;
    obl_d     = obl_q;
    owr_d     = owr_q;
    olast_d   = olast_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = '0;
    ram_wdata_o = ram_rdata_i;
    ram_re_o    = 1'b0;
    ram_raddr_o = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          new_d  = {req_tag_i, segment_count_i, is_write_i, block_count_i, start_block_i};
          rtag_d = req_tag_i;
          unique case (req_type_i)
            eio_pkg::REQ_SUBMIT: begin
              if (count_q == CNT_W'(QUEUE_DEPTH)) begin
                rstat_d = eio_pkg::ST_FULL;
                state_d = S_RESP;
              end else begin
                cur_d   = count_q;
                state_d = S_INS_RD;
              end
            end
            eio_pkg::REQ_CANCEL: begin
              cur_d   = '0;
              state_d = S_CAN_RD;
            end
            eio_pkg::REQ_DISPATCH: begin
              if (count_q == '0) begin
                rstat_d = eio_pkg::ST_EMPTY;
                rtag_d  = '0;
                state_d = S_RESP;
              end else begin
                attempt_d = '0;
                cur_d     = fwd_q ? '0 : count_q;
                state_d   = S_FND_RD;
              end
            end
            default: ;
          endcase
        end
      end

      // walk down from the top, moving larger starts up by one
      S_INS_RD: begin
        if (cur_q == '0) begin
          ram_we_o    = 1'b1;
          ram_waddr_o = '0;
          ram_wdata_o = new_q;
          count_d     = count_q + 1'b1;
          rstat_d     = eio_pkg::ST_ACCEPTED;
          state_d     = S_RESP;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = IDX_W'(cur_q - 1'b1);
          state_d     = S_INS_CHK;
        end
      end

      S_INS_CHK: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = cur_q[IDX_W-1:0];
        if (e_start > new_q[eio_pkg::START_W-1:0]) begin
          ram_wdata_o = ram_rdata_i;
          cur_d       = cur_q - 1'b1;
          state_d     = S_INS_RD;
        end else begin
          ram_wdata_o = new_q;
          count_d     = count_q + 1'b1;
          rstat_d     = eio_pkg::ST_ACCEPTED;
          state_d     = S_RESP;
        end
      end

      S_CAN_RD: begin
        if (cur_q == count_q) begin
          rstat_d = eio_pkg::ST_NOT_FOUND;
          state_d = S_RESP;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = cur_q[IDX_W-1:0];
          state_d     = S_CAN_CHK;
        end
      end

      S_CAN_CHK: begin
        if (e_tag == rtag_q) begin
          dst_d   = cur_q;
          amt_d   = CNT_W'(1);
          disp_d  = 1'b0;
          rstat_d = eio_pkg::ST_CANCELLED;
          state_d = S_SHF_RD;
        end else begin
          cur_d   = cur_q + 1'b1;
          state_d = S_CAN_RD;
        end
      end

      // forward looks at cur, backward at cur-1
      S_FND_RD: begin
        if (fwd_q ? (cur_q == count_q) : (cur_q == '0)) begin
          fwd_d  = t_fwd;
          head_d = t_head;
          if (attempt_q == 2'd2) begin
            rstat_d = eio_pkg::ST_EMPTY;
            rtag_d  = '0;
            state_d = S_RESP;
          end else begin
            attempt_d = attempt_q + 1'b1;
            cur_d     = t_fwd ? '0 : count_q;
          end
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = fwd_q ? cur_q[IDX_W-1:0] : IDX_W'(cur_q - 1'b1);
          state_d     = S_FND_CHK;
        end
      end

      S_FND_CHK: begin
        first_d  = 1'b1;
        at_end_d = 1'b0;
        nsum_d   = '0;
        blen_d   = '0;
        if (fwd_q) begin
          if (e_start >= head_q) begin
            state_d = S_MRG_RD;
          end else begin
            cur_d   = cur_q + 1'b1;
            state_d = S_FND_RD;
          end
        end else begin
          cur_d   = cur_q - 1'b1;
          state_d = (e_start <= head_q) ? S_MRG_RD : S_FND_RD;
        end
      end

      S_MRG_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = cur_q[IDX_W-1:0];
        state_d     = S_MRG_CHK;
      end

      S_MRG_CHK: begin
        pos_d = pe;
        cur_d = lo_q;
        state_d = S_EMT_RD;
        if (take) begin
          first_d = 1'b0;
          type_d  = etype;
          nsum_d  = nsum_new;
          blen_d  = blen_q + eio_pkg::BLEN_W'(e_len);
          lo_d    = lo_new;
          hi_d    = hi_new;
          cur_d   = lo_new;
          if (fwd_q) begin
            pos_d = pe + eio_pkg::POS_W'(e_len);
            if (cur_q + 1'b1 >= count_q) begin
              at_end_d = 1'b1;
            end else begin
              cur_d   = cur_q + 1'b1;
              state_d = S_MRG_RD;
            end
          end else begin
            if (cur_q == '0) begin
              at_end_d = 1'b1;
            end else begin
              cur_d   = cur_q - 1'b1;
              state_d = S_MRG_RD;
            end
          end
        end
      end

      S_EMT_RD: begin
        ram_re_o    = 1'b1;
        ram_raddr_o = cur_q[IDX_W-1:0];
        state_d     = S_EMT_CHK;
      end

      // read data holds while the output register is busy
      S_EMT_CHK: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = eio_pkg::ST_MEMBER;
          otag_d   = e_tag;
          owr_d    = type_q;
          olast_d  = is_last;
          obl_d    = is_last ? blen_q : '0;
          obs_d    = is_last ? ((cur_q == lo_q) ? e_start : bstart_q) : '0;
          if (cur_q == lo_q) begin
            bstart_d = e_start;
          end
          if (is_last) begin
            dst_d   = lo_q;
            amt_d   = hi_q - lo_q + 1'b1;
            disp_d  = 1'b1;
            state_d = S_SHF_RD;
          end else begin
            cur_d   = cur_q + 1'b1;
            state_d = S_EMT_RD;
          end
        end
      end

      // close the gap of amt entries starting at dst
      S_SHF_RD: begin
        if (src >= {1'b0, count_q}) begin
          count_d = count_q - amt_q;
          state_d = disp_q ? S_FIN : S_RESP;
        end else begin
          ram_re_o    = 1'b1;
          ram_raddr_o = src[IDX_W-1:0];
          state_d     = S_SHF_WR;
        end
      end

      S_SHF_WR: begin
        ram_we_o    = 1'b1;
        ram_waddr_o = dst_q[IDX_W-1:0];
        ram_wdata_o = ram_rdata_i;
        dst_d       = dst_q + 1'b1;
        state_d     = S_SHF_RD;
      end

      S_RESP: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = rstat_q;
          otag_d   = rtag_q;
          obs_d    = '0;
          obl_d    = '0;
          owr_d    = 1'b0;
          olast_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end

      S_FIN: begin
        head_d = (|pos_q[eio_pkg::POS_W-1:eio_pkg::START_W]) ? '1 :
                 pos_q[eio_pkg::START_W-1:0];
        if (at_end_q) begin
          fwd_d  = t_fwd;
          head_d = t_head;
        end
        state_d = S_IDLE;
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      fwd_q     <= 1'b1;
      head_q    <= '0;
      ovalid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      fwd_q     <= fwd_d;
      head_q    <= head_d;
      ovalid_q  <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    dst_q     <= dst_d;
    amt_q     <= amt_d;
    lo_q      <= lo_d;
    hi_q      <= hi_d;
    attempt_q <= attempt_d;
    first_q   <= first_d;
    at_end_q  <= at_end_d;
    disp_q    <= disp_d;
    type_q    <= type_d;
    pos_q     <= pos_d;
    nsum_q    <= nsum_d;
    blen_q    <= blen_d;
    bstart_q  <= bstart_d;
    new_q     <= new_d;
    rstat_q   <= rstat_d;
    rtag_q    <= rtag_d;
    ostat_q   <= ostat_d;
    otag_q    <= otag_d;
    obs_q     <= obs_d;
    obl_q     <= obl_d;
    owr_q     <= owr_d;
    olast_q   <= olast_d;
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign status_o       = ostat_q;
  assign out_tag_o      = otag_q;
  assign batch_start_o  = obs_q;
  assign batch_length_o = obl_q;
  assign batch_write_o  = owr_q;
  assign last_o         = olast_q;

  `EIO_ASSERT_IMP(a_count_range, 1'b1, count_q <= CNT_W'(QUEUE_DEPTH), "queue count overflow")
  `EIO_ASSERT_IMP(a_emit_window, state_q == S_EMT_CHK, (lo_q <= cur_q) && (cur_q <= hi_q), "emit outside batch")
  `EIO_ASSERT_NXT(a_busy_after_take, in_valid_i && !in_stall_o && (req_type_i != eio_pkg::REQ_RSVD), in_stall_o, "took a transaction but stayed idle")
  `EIO_ASSERT_IMP(a_shift_bound, state_q == S_SHF_WR, {1'b0, dst_q} < {1'b0, count_q}, "shift past queue end")

endmodule

@@ sv/elevator_io_scheduler_unit.sv @@
// submit, cancel and dispatch walk the queued entries and also wait on output stalls;
// each step reads the entry RAM and waits for its registered read data
// throughput: one transaction at a time, in_stall_o is high whenever the sequencer is not idle
// reset: queue empty, sweep forward from block 0, registers at their defaults
// the entry RAM itself is not cleared; only entries below the fill count are read
// ----------------------------------------------------------------------------
// elevator_io_scheduler_unit
// Elevator scheduler top: register file, sequencer and entry RAM.
// ----------------------------------------------------------------------------
module elevator_io_scheduler_unit #(
  parameter int QUEUE_DEPTH = eio_pkg::QUEUE_DEPTH_DEF,
  parameter int TAG_BITS    = eio_pkg::TAG_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [eio_pkg::ADDR_W-1:0]   paddr,
  input  logic [eio_pkg::DATA_W-1:0]   pwdata,
  output logic [eio_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [eio_pkg::TYPE_W-1:0]   req_type_i,
  input  logic [TAG_BITS-1:0]          req_tag_i,
  input  logic [eio_pkg::START_W-1:0]  start_block_i,
  input  logic [eio_pkg::LEN_W-1:0]    block_count_i,
  input  logic                         is_write_i,
  input  logic [eio_pkg::SEG_W-1:0]    segment_count_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [eio_pkg::STATUS_W-1:0] status_o,
  output logic [TAG_BITS-1:0]          out_tag_o,
  output logic [eio_pkg::START_W-1:0]  batch_start_o,
  output logic [eio_pkg::BLEN_W-1:0]   batch_length_o,
  output logic                         batch_write_o,
  output logic                         last_o
);

  localparam int ENT_W = eio_pkg::ENT_TAG_LSB + TAG_BITS;
  localparam int IDX_W = $clog2(QUEUE_DEPTH);

  eio_pkg::cfg_t    cfg;
  logic             ram_we;
  logic [IDX_W-1:0] ram_waddr;
  logic [ENT_W-1:0] ram_wdata;
  logic             ram_re;
  logic [IDX_W-1:0] ram_raddr;
  logic [ENT_W-1:0] ram_rdata;

  eio_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  eio_ram #(
    .WIDTH (ENT_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  eio_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TAG_BITS    (TAG_BITS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .req_type_i      (req_type_i),
    .req_tag_i       (req_tag_i),
    .start_block_i   (start_block_i),
    .block_count_i   (block_count_i),
    .is_write_i      (is_write_i),
    .segment_count_i (segment_count_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .out_tag_o       (out_tag_o),
    .batch_start_o   (batch_start_o),
    .batch_length_o  (batch_length_o),
    .batch_write_o   (batch_write_o),
    .last_o          (last_o),
    .ram_we_o        (ram_we),
    .ram_waddr_o     (ram_waddr),
    .ram_wdata_o     (ram_wdata),
    .ram_re_o        (ram_re),
    .ram_raddr_o     (ram_raddr),
    .ram_rdata_i     (ram_rdata)
  );

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench of the elevator request scheduler: a built-in predictor tracks the
// sorted queue, sweep direction and head position, and every result
// transaction is compared field by field against it under random idling.
// ----------------------------------------------------------------------------
module tb_top;
  import eio_pkg::*;

  localparam int DEPTH     = QUEUE_DEPTH_DEF;
  localparam int TB_TAG_W  = TAG_BITS_DEF;
  localparam int WD_LIMIT  = 20000;
  localparam int QUIET_CYC = 1000;

  typedef struct packed {
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   len;
    logic               wr;
    logic [SEG_W-1:0]   seg;
    logic [TB_TAG_W-1:0] tag;
  } pend_req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [TB_TAG_W-1:0] tag;
    logic [START_W-1:0]  bstart;
    logic [BLEN_W-1:0]   blen;
    logic                bwr;
    logic                last;
  } sched_res_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic pready;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [TYPE_W-1:0] req_type_i = REQ_SUBMIT;
  logic [TB_TAG_W-1:0] req_tag_i = '0;
  logic [START_W-1:0] start_block_i = '0;
  logic [LEN_W-1:0] block_count_i = '0;
  logic is_write_i = 1'b0;
  logic [SEG_W-1:0] segment_count_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [STATUS_W-1:0] status_o;
  logic [TB_TAG_W-1:0] out_tag_o;
  logic [START_W-1:0] batch_start_o;
  logic [BLEN_W-1:0] batch_length_o;
  logic batch_write_o;
  logic last_o;

  elevator_io_scheduler_unit u_top (.*);

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor state
  pend_req_t         pend_q[$];
  sched_res_t        want_q[$];
  logic              sweep_fwd = 1'b1;
  logic [START_W-1:0] head_pos = '0;
  logic              cfg_bidir = BIDIR_RST;
  logic [LIMIT_W-1:0] cfg_limit = SEG_LIM_RST;
  logic [START_W-1:0] cfg_dev = DEV_BLK_RST;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_left = 0;
  int mismatches = 0;
  int watchdog = 0;
  logic [START_W-1:0] last_end = '0;

  // values sampled on the falling edge before each rising edge
  logic in_hit = 1'b0, out_hit = 1'b0, apb_hit = 1'b0;
  sched_res_t seen;

  always @(negedge clk_i) begin
    in_hit  <= in_valid_i && !in_stall_o;
    out_hit <= out_valid_o && !out_stall_i;
    apb_hit <= psel && penable && pwrite && pready;
    seen    <= '{status_o, out_tag_o, batch_start_o, batch_length_o, batch_write_o, last_o};
  end

  function automatic sched_res_t mk_res(logic [STATUS_W-1:0] st, logic [TB_TAG_W-1:0] tg,
                                        logic [START_W-1:0] bs, logic [BLEN_W-1:0] bl,
                                        logic bw, logic lst);
    sched_res_t r;
    r = '{st, tg, bs, bl, bw, lst};
    return r;
  endfunction

  // queue one expected result at the tail
  task automatic want_add(sched_res_t r);
    want_q.insert(want_q.size(), r);
  endtask

  task automatic sweep_turn();
    sweep_fwd = cfg_bidir ? !sweep_fwd : 1'b1;
    head_pos  = sweep_fwd ? '0 : cfg_dev;
  endtask

  function automatic int first_rank();
    if (sweep_fwd) begin
      for (int i = 0; i < pend_q.size(); i++)
        if (pend_q[i].start >= head_pos) return i;
    end else begin
      for (int i = pend_q.size() - 1; i >= 0; i--)
        if (pend_q[i].start <= head_pos) return i;
    end
    return -1;
  endfunction

  task automatic predict_dispatch();
    int r, lo, hi, taken;
    logic [12:0] nsum;
    logic [BLEN_W-1:0] blen;
    logic [63:0] pos;
    logic bwr, at_end;
    r = -1;
    at_end = 1'b0;
    for (int a = 0; a < 3 && pend_q.size() > 0; a++) begin
      r = first_rank();
      if (r >= 0) break;
      sweep_turn();
    end
    if (r < 0) begin
      want_add(mk_res(ST_EMPTY, '0, '0, '0, 1'b0, 1'b1));
      return;
    end
    lo = r; hi = r; taken = 0; nsum = '0; blen = '0;
    bwr = pend_q[r].wr;
    pos = {32'b0, pend_q[r].start};
    forever begin
      if (pos != {32'b0, pend_q[r].start} || pend_q[r].wr != bwr) break;
      if (taken > 0 && nsum + pend_q[r].seg >= cfg_limit) break;
      nsum += pend_q[r].seg;
      blen += pend_q[r].len;
      taken++;
      if (r < lo) lo = r;
      if (r > hi) hi = r;
      if (sweep_fwd) begin
        pos += pend_q[r].len;
        if (r + 1 >= pend_q.size()) begin
          at_end = 1'b1;
          break;
        end
        r++;
      end else begin
        if (r == 0) begin
          at_end = 1'b1;
          break;
        end
        r--;
        if ({32'b0, pend_q[r].start} + pend_q[r].len == pos) pos = {32'b0, pend_q[r].start};
      end
    end
    for (int i = lo; i <= hi; i++)
      want_add(mk_res(ST_MEMBER, pend_q[i].tag, (i == hi) ? pend_q[lo].start : '0,
                      (i == hi) ? blen : '0, bwr, i == hi));
    for (int i = 0; i < taken; i++) pend_q.delete(lo);
    head_pos = (pos > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : pos[31:0];
    if (at_end) sweep_turn();
  endtask

  task automatic predict_req(logic [TYPE_W-1:0] kind, pend_req_t e);
    int rank;
    case (kind)
      REQ_SUBMIT: begin
        if (pend_q.size() >= DEPTH) begin
          want_add(mk_res(ST_FULL, e.tag, '0, '0, 1'b0, 1'b1));
        end else begin
          rank = 0;
          while (rank < pend_q.size() && pend_q[rank].start <= e.start) rank++;
          pend_q.insert(rank, e);
          want_add(mk_res(ST_ACCEPTED, e.tag, '0, '0, 1'b0, 1'b1));
        end
      end
      REQ_CANCEL: begin
        rank = -1;
        foreach (pend_q[i])
          if (rank < 0 && pend_q[i].tag == e.tag) rank = i;
        if (rank >= 0) pend_q.delete(rank);
        want_add(mk_res(rank >= 0 ? ST_CANCELLED : ST_NOT_FOUND, e.tag,
                        '0, '0, 1'b0, 1'b1));
      end
      REQ_DISPATCH: predict_dispatch();
      default: ;
    endcase
  endtask

  // result checker and receiver stall
  always @(posedge clk_i) begin
    if (out_hit) begin
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction: %p", seen);
      end else begin
        if (seen !== want_q[0]) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want_q[0], seen);
        end
        void'(want_q.pop_front());
      end
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      hold_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (in_hit || out_hit || apb_hit) watchdog = 0;
    else watchdog++;
    if (watchdog >= WD_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [DATA_W-1:0] val);
    @(posedge clk_i);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= ADDR_W'(idx) << 2; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_BIDIR:   cfg_bidir = val[0];
      REG_SEG_LIM: cfg_limit = val[LIMIT_W-1:0];
      REG_DEV_BLK: cfg_dev = val;
      default: ;
    endcase
  endtask

  // send one request; valid stays high into the next call unless it idles
  task automatic send_req(logic [TYPE_W-1:0] kind, logic [TB_TAG_W-1:0] tg,
                          logic [START_W-1:0] st, logic [LEN_W-1:0] cnt, logic wr,
                          logic [SEG_W-1:0] seg);
    pend_req_t e;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind; req_tag_i <= tg; start_block_i <= st;
    block_count_i <= cnt; is_write_i <= wr; segment_count_i <= seg;
    do @(posedge clk_i); while (!in_hit);
    e = '{st, cnt, wr, seg, tg};
    predict_req(kind, e);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (want_q.size() != 0) @(posedge clk_i);
    // requests with no result may still be in flight
    repeat (QUIET_CYC) @(posedge clk_i);
  endtask

  task automatic send_random();
    int pick;
    logic [START_W-1:0] st;
    logic [LEN_W-1:0] cnt;
    logic [SEG_W-1:0] seg;
    pick = $urandom_range(99);
    if (pick < 50) begin
      case ($urandom_range(9))
        0, 1, 2, 3, 4: st = last_end;
        5, 6, 7: st = $urandom_range(3000);
        default: st = $urandom;
      endcase
      cnt = ($urandom_range(19) == 0) ? LEN_W'($urandom_range(65535, 1)) :
                                        LEN_W'($urandom_range(64, 1));
      seg = ($urandom_range(9) == 0) ? SEG_W'($urandom_range(64, 1)) :
                                       SEG_W'($urandom_range(20, 1));
      last_end = st + START_W'(cnt);
      send_req(REQ_SUBMIT, TB_TAG_W'($urandom_range(255)), st, cnt, $urandom_range(3) == 0,
               seg);
    end else if (pick < 68) begin
      if (pend_q.size() > 0 && $urandom_range(9) < 8)
        send_req(REQ_CANCEL, pend_q[$urandom_range(pend_q.size() - 1)].tag, $urandom,
                 LEN_W'($urandom), 1'($urandom), SEG_W'($urandom));
      else
        send_req(REQ_CANCEL, TB_TAG_W'($urandom_range(255)), $urandom, LEN_W'($urandom),
                 1'($urandom), SEG_W'($urandom));
    end else if (pick < 97) begin
      send_req(REQ_DISPATCH, TB_TAG_W'($urandom), $urandom, LEN_W'($urandom), 1'($urandom),
               SEG_W'($urandom));
    end else begin
      send_req(REQ_RSVD, TB_TAG_W'($urandom), $urandom, LEN_W'($urandom), 1'($urandom),
               SEG_W'($urandom));
    end
  endtask

  task automatic t_directed();
    reg_write(REG_BIDIR, 32'd1);
    reg_write(REG_SEG_LIM, 32'd512);
    reg_write(REG_DEV_BLK, 32'hFFFF_FFFF);
    send_req(REQ_DISPATCH, 8'd0, '0, '0, 1'b0, '0);
    send_req(REQ_RSVD, 8'hFF, '1, '1, 1'b1, '1);
    send_req(REQ_CANCEL, 8'd9, '0, '0, 1'b0, '0);
    send_req(REQ_SUBMIT, 8'd0, 32'd0, 16'hFFFF, 1'b0, 7'd64);
    send_req(REQ_SUBMIT, 8'd255, 32'd65535, 16'd1, 1'b0, 7'd1);
    send_req(REQ_SUBMIT, 8'd7, 32'd65535, 16'd1, 1'b1, 7'd1);
    send_req(REQ_SUBMIT, 8'd7, 32'd100, 16'd4, 1'b1, 7'd3);
    send_req(REQ_CANCEL, 8'd7, '0, '0, 1'b0, '0);
    send_req(REQ_SUBMIT, 8'd8, 32'hFFFF_FFFF, 16'hFFFF, 1'b1, 7'd64);
    repeat (4) send_req(REQ_DISPATCH, 8'd0, '0, '0, 1'b0, '0);
    send_req(REQ_SUBMIT, 8'd1, 32'd1000, 16'd10, 1'b0, 7'd2);
    send_req(REQ_SUBMIT, 8'd2, 32'd990, 16'd10, 1'b0, 7'd2);
    send_req(REQ_SUBMIT, 8'd3, 32'd980, 16'd10, 1'b0, 7'd2);
    repeat (2) send_req(REQ_DISPATCH, 8'd0, '0, '0, 1'b0, '0);
    drain();
    // first member is taken even when it alone reaches the limit
    reg_write(REG_SEG_LIM, 32'd1);
    reg_write(REG_BIDIR, 32'd0);
    send_req(REQ_SUBMIT, 8'd4, 32'd50, 16'd5, 1'b1, 7'd64);
    send_req(REQ_SUBMIT, 8'd5, 32'd55, 16'd5, 1'b1, 7'd1);
    repeat (3) send_req(REQ_DISPATCH, 8'd0, '0, '0, 1'b0, '0);
    drain();
  endtask

  task automatic send_random_submit();
    logic [START_W-1:0] st;
    st = ($urandom_range(1) == 0) ? last_end : START_W'($urandom_range(5000));
    last_end = st + 32'd8;
    send_req(REQ_SUBMIT, TB_TAG_W'($urandom), st, 16'd8, 1'($urandom_range(1)),
             SEG_W'($urandom_range(64, 1)));
  endtask

  task automatic t_queue_full();
    reg_write(REG_SEG_LIM, 32'd1024);
    reg_write(REG_BIDIR, 32'd1);
    repeat (DEPTH + 1) send_random_submit();
    while (pend_q.size() > 0) send_req(REQ_DISPATCH, '0, '0, '0, 1'b0, '0);
    drain();
  endtask

  task automatic t_backpressure();
    send_idle_pct = 0;
    hold_left = 400;
    repeat (12) send_random();
    drain();
  endtask

  task automatic t_random(int n, int idle, int stall, logic bd, logic [10:0] lim,
                          logic [31:0] dev);
    reg_write(REG_BIDIR, {31'b0, bd});
    reg_write(REG_SEG_LIM, {21'b0, lim});
    reg_write(REG_DEV_BLK, dev);
    send_idle_pct = idle;
    recv_stall_pct = stall;
    for (int i = 0; i < n; i++) begin
      send_random();
      // stretches without idling inside each phase
      if (i == n / 2) begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
    end
    drain();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);
    t_directed();
    t_queue_full();
    t_backpressure();
    t_random(10, 0, 0, 1'b1, 11'd512, 32'hFFFF_FFFF);
    t_random(10, 82, 0, 1'b0, 11'd1024, 32'd0);
    t_random(10, 0, 82, 1'b1, 11'd8, 32'd5000);
    t_random(10, 31, 31, 1'b1, 11'd40, 32'd123456);
    if (mismatches == 0 && want_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
